### rtl/core/pci_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, limits, register indexes and controller/datapath command types.
// ----------------------------------------------------------------------------
package pci_pkg;

    localparam int OUT_LIMIT      = 10000;
    localparam int GAIN_FRAC_BITS = 8;

    localparam int SMP_W  = 16;
    localparam int ERR_W  = SMP_W + 1;
    localparam int D1_W   = ERR_W + 1;
    localparam int D2_W   = ERR_W + 2;
    localparam int SUM_W  = 32;
    localparam int GAIN_W = 16;
    localparam int DRV_W  = 15;

    localparam int CLAMP_NUM = OUT_LIMIT * (2 ** GAIN_FRAC_BITS);
    localparam int NUM_W     = $clog2(CLAMP_NUM + 1);
    localparam int CNT_W     = $clog2(NUM_W + 1);

    localparam int OPA_W  = GAIN_W + 1;
    localparam int OPB_W  = SUM_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = CFG_IDX_W'(3);

    localparam logic MODE_POS = 1'b0;
    localparam logic MODE_INC = 1'b1;

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       do_err;
        logic       mul_en;
        logic [1:0] term;
        logic       acc_load;
        logic       acc_add;
        logic       do_fin;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/pci_ifs.sv
// ----------------------------------------------------------------------------
// PID controller channels
// Sample input, drive output and register write channels.
// ----------------------------------------------------------------------------
interface pci_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pci_pkg::SMP_W-1:0]   setpoint;
    logic signed [pci_pkg::SMP_W-1:0]   measurement;

    modport source (output valid, output setpoint, output measurement, input ready);
    modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

interface pci_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pci_pkg::DRV_W-1:0]   drive;
    logic                               clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface pci_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pci_pkg::CFG_IDX_W-1:0]      index;
    logic [pci_pkg::CFG_DAT_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/pci_div.sv
// ----------------------------------------------------------------------------
// PID controller clamp-bound divider
// Restoring divider, one quotient bit per cycle: bound = CLAMP_NUM / gain_i.
// ----------------------------------------------------------------------------
module pci_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pci_pkg::GAIN_W-1:0]   i_den,
    output logic                         o_busy,
    output logic [pci_pkg::NUM_W-1:0]    o_quot
);
    import pci_pkg::*;

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [GAIN_W-1:0] r_rem;
    logic [GAIN_W-1:0] r_den;
    logic [NUM_W-1:0]  r_q;

    logic [GAIN_W:0]   w_trial;
    logic [GAIN_W:0]   w_diff;
    logic              w_qbit;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_qbit  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= NUM_W'(CLAMP_NUM);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[GAIN_W-1:0] : w_trial[GAIN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

### rtl/core/pci_ctrl.sv
// ----------------------------------------------------------------------------
// PID controller sequencer
// Steps each item through error update, three gain products and output.
// ----------------------------------------------------------------------------
module pci_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pci_pkg::t_sts i_sts,
    output pci_pkg::t_cmd o_cmd
);
    import pci_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ERR  = 3'd1;
    localparam logic [2:0] S_M0   = 3'd2;
    localparam logic [2:0] S_M1   = 3'd3;
    localparam logic [2:0] S_M2   = 3'd4;
    localparam logic [2:0] S_M3   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE) && !i_sts.div_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.do_err = 1'b1;
                n_state      = S_M0;
            end
            S_M0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.term   = TERM_P;
                n_state      = S_M1;
            end
            S_M1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.term     = TERM_I;
                o_cmd.acc_load = 1'b1;
                n_state        = S_M2;
            end
            S_M2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.term    = TERM_D;
                o_cmd.acc_add = 1'b1;
                n_state       = S_M3;
            end
            S_M3: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.do_fin = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_to_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_ERR))
        else $error("accepted item did not enter error update");

    a_hold_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_busy |-> !o_in_ready)
        else $error("input ready while clamp bound is being computed");

    a_products_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M3) |=> (r_state == S_FIN))
        else $error("product sequence did not reach output stage");

    a_fin_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.do_fin |-> i_sts.out_free)
        else $error("output written while previous item still held");

endmodule

### rtl/core/pci_dp.sv
// ----------------------------------------------------------------------------
// PID controller datapath
// Registers, error history, error sum, shared multiplier, scaling and clamp.
// ----------------------------------------------------------------------------
module pci_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pci_pkg::t_cmd                     i_cmd,
    output pci_pkg::t_sts                     o_sts,
    input  logic signed [pci_pkg::SMP_W-1:0]  i_setpoint,
    input  logic signed [pci_pkg::SMP_W-1:0]  i_measurement,
    input  logic                              i_cfg_valid,
    input  logic [pci_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pci_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [pci_pkg::DRV_W-1:0]  o_drive,
    output logic                              o_clamped
);
    import pci_pkg::*;

    localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(OUT_LIMIT);
    localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic              r_mode;
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;

    logic signed [ERR_W-1:0]  r_e;
    logic signed [ERR_W-1:0]  r_e1;
    logic signed [ERR_W-1:0]  r_e2;
    logic signed [D1_W-1:0]   r_d1;
    logic signed [D2_W-1:0]   r_d2;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DRV_W-1:0]  r_held;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [DRV_W-1:0]  r_drive;
    logic                     r_clamped;

    logic                     w_div_start;
    logic                     w_div_busy;
    logic [NUM_W-1:0]         w_bound;

    logic signed [D1_W-1:0]   n_d1;
    logic signed [D2_W-1:0]   n_d2;
    logic signed [SUM_W:0]    n_s33;
    logic signed [SUM_W-1:0]  n_sat;
    logic signed [SUM_W-1:0]  n_bnd;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [OPA_W-1:0]  n_opa;
    logic signed [OPB_W-1:0]  n_opb;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  n_prod_ext;
    logic signed [ACC_W-1:0]  n_y;
    logic signed [DRV_W-1:0]  n_drive;
    logic                     n_clamped;

    assign w_div_start = i_cfg_valid && (i_cfg_index == REG_GAIN_I);

    pci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (i_cfg_data[GAIN_W-1:0]),
        .o_busy  (w_div_busy),
        .o_quot  (w_bound)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_POS;
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:   r_mode   <= i_cfg_data[0];
                REG_GAIN_P: r_gain_p <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I: r_gain_i <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D: r_gain_d <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_d1  = D1_W'(r_e) - D1_W'(r_e1);
        n_d2  = D2_W'(r_e) - (D2_W'(r_e1) <<< 1) + D2_W'(r_e2);
        n_s33 = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_e);
        if (n_s33[SUM_W] != n_s33[SUM_W-1]) begin
            n_sat = n_s33[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sat = n_s33[SUM_W-1:0];
        end
        n_bnd = {{(SUM_W-NUM_W){1'b0}}, w_bound};
        n_sum = n_sat;
        if (r_gain_i != '0) begin
            priority if (n_sat > n_bnd) begin
                n_sum = n_bnd;
            end else if (n_sat < -n_bnd) begin
                n_sum = -n_bnd;
            end
        end
    end

    always_comb begin
        n_opa = '0;
        n_opb = '0;
        unique case (i_cmd.term)
            TERM_P: begin
                n_opa = {1'b0, r_gain_p};
                n_opb = (r_mode == MODE_INC) ? OPB_W'(r_d1) : OPB_W'(r_e);
            end
            TERM_I: begin
                n_opa = {1'b0, r_gain_i};
                n_opb = (r_mode == MODE_INC) ? OPB_W'(r_e) : OPB_W'(r_sum);
            end
            TERM_D: begin
                n_opa = {1'b0, r_gain_d};
                n_opb = (r_mode == MODE_INC) ? OPB_W'(r_d2) : OPB_W'(r_d1);
            end
            default: begin
            end
        endcase
        n_prod     = n_opa * n_opb;
        n_prod_ext = ACC_W'(r_prod);
    end

    always_comb begin
        n_y = r_acc >>> GAIN_FRAC_BITS;
        if (r_mode == MODE_INC) begin
            n_y = n_y + ACC_W'(r_held);
        end
        n_clamped = 1'b0;
        n_drive   = n_y[DRV_W-1:0];
        priority if (n_y > LIM_HI) begin
            n_drive   = LIM_HI[DRV_W-1:0];
            n_clamped = 1'b1;
        end else if (n_y < LIM_LO) begin
            n_drive   = LIM_LO[DRV_W-1:0];
            n_clamped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1        <= '0;
            r_e2        <= '0;
            r_sum       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_err) begin
                r_e1 <= r_e;
                if (r_mode == MODE_INC) begin
                    r_e2 <= r_e1;
                end else begin
                    r_sum <= n_sum;
                end
            end
            if (i_cmd.do_fin) begin
                r_held      <= n_drive;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_e <= ERR_W'(i_setpoint) - ERR_W'(i_measurement);
        end
        if (i_cmd.do_err) begin
            r_d1 <= n_d1;
            r_d2 <= n_d2;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.acc_load) begin
            r_acc <= n_prod_ext;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + n_prod_ext;
        end
        if (i_cmd.do_fin) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_sts.div_busy = w_div_busy;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_clamped   = r_clamped;

endmodule

### rtl/core/pid_controller_pos_incr_unit.sv
// ----------------------------------------------------------------------------
// PID controller, positional and incremental form
// Fixed-point PID step per sample with output limit and integral clamp.
// ----------------------------------------------------------------------------
// Channels: i_in takes one sample item (setpoint, measurement); o_out returns
// one item per sample (drive, clamped); i_cfg writes mode, gain_p, gain_i and
// gain_d by index, always ready, and ignores indexes beyond the list.
// The sequencer runs the error update, three products on one shared multiplier
// and the final clamp for each item, and accepts a new input item only after
// the previous one has reached the output register.
// A write to gain_i starts a bit-serial division for the integral clamp bound;
// i_in.ready stays low until it completes.
// Reset clears the registers, error history, error sum and held drive.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result is held back until the receiver takes the
// previous one.
// ----------------------------------------------------------------------------
module pid_controller_pos_incr_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pci_in_if.sink    i_in,
    pci_out_if.source o_out,
    pci_cfg_if.sink   i_cfg
);
    import pci_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    pci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pci_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_setpoint    (i_in.setpoint),
        .i_measurement (i_in.measurement),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_drive       (o_out.drive),
        .o_clamped     (o_out.clamped)
    );

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives setpoint/measurement items through the positional and incremental
// forms under several gain settings. Every drive item is checked against a
// directed expected value or an in-bench fixed-point PID model. The bench idles
// both channels at random and holds off the receiver twice for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pci_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint LIMIT   = OUT_LIMIT;

    localparam logic signed [SMP_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] S_MIN = 16'sh8000;
    localparam logic signed [DRV_W-1:0] D_LIM = DRV_W'(OUT_LIMIT);

    localparam logic [CFG_IDX_W-1:0] REG_PAST_END  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE = '1;

    typedef struct packed {
        logic signed [DRV_W-1:0] drive;
        logic                    clamped;
    } drive_item_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DAT_W-1:0]    data;
        logic signed [SMP_W-1:0] sp;
        logic signed [SMP_W-1:0] meas;
        logic                    known;
        logic signed [DRV_W-1:0] drive;
        logic                    clamped;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pci_in_if  sample_if ();
    pci_out_if drive_if ();
    pci_cfg_if cfg_if ();

    pid_controller_pos_incr_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (sample_if),
        .o_out   (drive_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic                    pid_mode  = MODE_POS;
    logic [GAIN_W-1:0]       kp        = '0;
    logic [GAIN_W-1:0]       ki        = '0;
    logic [GAIN_W-1:0]       kd        = '0;
    logic signed [ERR_W-1:0] err_prev  = '0;
    logic signed [ERR_W-1:0] err_prev2 = '0;
    logic signed [SUM_W-1:0] err_accum = '0;
    logic signed [DRV_W-1:0] drive_acc = '0;

    drive_item_t drive_expect_q [$];
    int          failures  = 0;
    int          burst_left = 0;

    step_row_t directed_steps [0:30] = '{
        '{ROW_SAMPLE, REG_MODE, 16'h0000, 16'sd0, 16'sd0, 1'b1, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MAX, S_MIN, 1'b1, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_GAIN_P, 16'h0100, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, 16'sd100, 16'sd0, 1'b1, 15'sd100, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MAX, S_MIN, 1'b1, D_LIM, 1'b1},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MIN, S_MAX, 1'b1, -D_LIM, 1'b1},
        '{ROW_WRITE, REG_GAIN_P, 16'h0001, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, -16'sd1, 16'sd0, 1'b1, -15'sd1, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, 16'sd1, 16'sd0, 1'b1, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_GAIN_P, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, 16'sd1, 16'sd0, 1'b1, 15'sd255, 1'b0},
        '{ROW_WRITE, REG_GAIN_I, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_GAIN_P, 16'h0000, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MIN, S_MAX, 1'b0, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_GAIN_I, 16'h0001, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_GAIN_D, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MAX, S_MIN, 1'b1, D_LIM, 1'b1},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MIN, S_MAX, 1'b1, -D_LIM, 1'b1},
        '{ROW_WRITE, REG_MODE, 16'(MODE_INC), 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MAX, S_MIN, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MIN, S_MAX, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MAX, S_MIN, 1'b0, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_PAST_END, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_LAST_CODE, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, 16'sd5, 16'sd3, 1'b0, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_GAIN_P, 16'h0000, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_GAIN_I, 16'h0000, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_GAIN_D, 16'h0000, 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0},
        '{ROW_SAMPLE, REG_MODE, 16'h0000, S_MIN, S_MIN, 1'b0, 15'sd0, 1'b0},
        '{ROW_WRITE, REG_MODE, 16'(MODE_POS), 16'sd0, 16'sd0, 1'b0, 15'sd0, 1'b0}
    };

    function automatic drive_item_t pid_predict(input logic signed [SMP_W-1:0] sp,
                                                input logic signed [SMP_W-1:0] meas);
        longint      e;
        longint      e1;
        longint      e2;
        longint      s;
        longint      bound;
        longint      y;
        drive_item_t r;
        e  = longint'(sp) - longint'(meas);
        e1 = longint'(err_prev);
        e2 = longint'(err_prev2);
        s  = longint'(err_accum);
        r.clamped = 1'b0;
        if (pid_mode == MODE_POS) begin
            s = s + e;
            if (s > SUM_MAX) s = SUM_MAX;
            if (s < SUM_MIN) s = SUM_MIN;
            if (ki != '0) begin
                bound = (LIMIT <<< GAIN_FRAC_BITS) / longint'(ki);
                if (s > bound) s = bound;
                if (s < -bound) s = -bound;
            end
            y = (longint'(kp) * e + longint'(ki) * s + longint'(kd) * (e - e1))
                >>> GAIN_FRAC_BITS;
            err_accum = s[SUM_W-1:0];
        end else begin
            y = longint'(drive_acc)
              + ((longint'(kp) * (e - e1) + longint'(ki) * e
                  + longint'(kd) * (e - 2 * e1 + e2)) >>> GAIN_FRAC_BITS);
            err_prev2 = e1[ERR_W-1:0];
        end
        if (y > LIMIT) begin
            y = LIMIT;
            r.clamped = 1'b1;
        end
        if (y < -LIMIT) begin
            y = -LIMIT;
            r.clamped = 1'b1;
        end
        drive_acc = y[DRV_W-1:0];
        err_prev  = e[ERR_W-1:0];
        r.drive   = y[DRV_W-1:0];
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return GAIN_W'(1);
            3: return GAIN_W'(256);
            4, 5: return GAIN_W'($urandom_range(0, 1536));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [SMP_W-1:0] corner_sample();
        case ($urandom_range(0, 3))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (idx)
            REG_MODE:   pid_mode = data[0];
            REG_GAIN_P: kp = data[GAIN_W-1:0];
            REG_GAIN_I: ki = data[GAIN_W-1:0];
            REG_GAIN_D: kd = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] sp,
                               input logic signed [SMP_W-1:0] meas,
                               input logic known, input drive_item_t given);
        int          gap;
        drive_item_t r;
        if (cfg_if.valid) cfg_if.valid <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                sample_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        sample_if.valid       <= 1'b1;
        sample_if.setpoint    <= sp;
        sample_if.measurement <= meas;
        @(posedge clk);
        while (!sample_if.ready) @(posedge clk);
        if (burst_left > 0) burst_left--;
        r = pid_predict(sp, meas);
        drive_expect_q.push_back(known ? given : r);
    endtask

    task automatic drain_block();
        sample_if.valid <= 1'b0;
        if (cfg_if.valid) cfg_if.valid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        int                      window_left;
        int                      stall_pct;
        int                      hold_left;
        int                      seen;
        drive_item_t             want;
        window_left = 0;
        stall_pct   = 0;
        hold_left   = 0;
        seen        = 0;
        drive_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (drive_if.valid && drive_if.ready) begin
                if (drive_expect_q.size() == 0) begin
                    $error("drive item %0d arrived with nothing expected", drive_if.drive);
                    failures++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (drive_if.drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d", want.drive, drive_if.drive);
                        failures++;
                    end
                    if (drive_if.clamped !== want.clamped) begin
                        $error("clamped: expected %0d, actual %0d",
                               want.clamped, drive_if.clamped);
                        failures++;
                    end
                end
                seen++;
                if (seen == 150 || seen == 600) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                drive_if.ready <= 1'b0;
            end else begin
                if (window_left == 0) begin
                    window_left = $urandom_range(8, 120);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 20;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                window_left--;
                drive_if.ready <= ($urandom_range(1, 100) > stall_pct);
            end
        end
    end

    initial begin
        int                      random_sent;
        int                      len;
        logic                    first;
        logic signed [SMP_W-1:0] target;
        logic signed [SMP_W-1:0] sp;
        logic signed [SMP_W-1:0] meas;
        random_sent = 0;
        first       = 1'b1;
        rst_n                 <= 1'b0;
        sample_if.valid       <= 1'b0;
        sample_if.setpoint    <= '0;
        sample_if.measurement <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= '0;
        cfg_if.data           <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[n]) begin
            if (directed_steps[n].kind == ROW_WRITE) begin
                drain_block();
                write_reg(directed_steps[n].idx, directed_steps[n].data);
            end else begin
                send_sample(directed_steps[n].sp, directed_steps[n].meas,
                            directed_steps[n].known,
                            {directed_steps[n].drive, directed_steps[n].clamped});
            end
        end

        while (random_sent < RANDOM_ITEMS) begin
            drain_block();
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DAT_W'($urandom));
            if (first || $urandom_range(0, 1)) write_reg(REG_MODE, CFG_DAT_W'($urandom));
            if (first || $urandom_range(0, 1)) write_reg(REG_GAIN_P, pick_gain());
            if (first || $urandom_range(0, 1)) write_reg(REG_GAIN_D, pick_gain());
            if (first || $urandom_range(0, 1)) write_reg(REG_GAIN_I, pick_gain());
            first  = 1'b0;
            target = SMP_W'($urandom);
            len    = $urandom_range(10, 60);
            repeat (len) begin
                case ($urandom_range(0, 9))
                    0: begin
                        sp   = corner_sample();
                        meas = corner_sample();
                    end
                    1, 2, 3: begin
                        sp   = SMP_W'($urandom);
                        meas = SMP_W'($urandom);
                    end
                    default: begin
                        sp   = target;
                        meas = target + SMP_W'($urandom_range(0, 600)) - 16'sd300;
                    end
                endcase
                send_sample(sp, meas, 1'b0, '0);
                random_sent++;
            end
        end

        drain_block();

        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### pid_controller_pos_incr_unit.f
rtl/core/pci_pkg.sv
rtl/core/pci_ifs.sv
rtl/core/pci_div.sv
rtl/core/pci_ctrl.sv
rtl/core/pci_dp.sv
rtl/core/pid_controller_pos_incr_unit.sv
verif/testbench.sv
